[src/csp_pkg.sv]
// ----------------------------------------------------------------------------
// csp_pkg
// Shared constants, types and ROM builders for the contrast sweep generator.
// ----------------------------------------------------------------------------
package csp_pkg;

    // raster and table sizes
    localparam int IMAGE_WIDTH      = 800;
    localparam int IMAGE_HEIGHT     = 600;
    localparam int SINE_TABLE_DEPTH = 1024;

    // payload field widths
    localparam int COLUMN_W = 10;
    localparam int ROW_W    = 10;
    localparam int PIXEL_W  = 8;

    // table word widths
    localparam int PHASE_W = 16;   // Q0.16 cycle fraction
    localparam int AMP_W   = 16;   // unsigned Q8.8
    localparam int SINE_W  = 16;   // signed Q1.15

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] Q30_MASK    = Q30_ONE - 64'd1;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic        [PHASE_W-1:0] t_phase_rom [IMAGE_WIDTH];
    typedef logic        [AMP_W-1:0]   t_amp_rom   [IMAGE_HEIGHT];
    typedef logic signed [SINE_W-1:0]  t_sine_rom  [SINE_TABLE_DEPTH];

    // log2 of an integer >= 1, Q30 result
    function automatic logic [63:0] log2_q30(input logic [63:0] b);
        logic [63:0] bb;
        logic [63:0] ipart;
        logic [63:0] m;
        logic [63:0] res;
        int          j;
        int          i;
        bb    = (b < 64'd1) ? 64'd1 : b;
        ipart = 64'd0;
        for (j = 0; j < 63; j++) begin
            if ((bb >> (ipart + 64'd1)) != 64'd0) begin
                ipart = ipart + 64'd1;
            end
        end
        m   = (bb << 30) >> ipart;
        res = ipart << 30;
        for (i = 1; i <= 30; i++) begin
            m = (m * m) >> 30;
            if (m >= (Q30_ONE << 1)) begin
                m   = m >> 1;
                res = res | (64'd1 << (30 - i));
            end
        end
        return res;
    endfunction

    // 2^y, y and result in Q30; Taylor series on the fractional part
    function automatic logic [63:0] exp2_q30(input logic [63:0] y);
        logic [63:0] k;
        logic [63:0] z;
        logic [63:0] sum;
        logic [63:0] term;
        int          n;
        k    = y >> 30;
        z    = ((y & Q30_MASK) * LN2_Q30) >> 30;
        sum  = Q30_ONE;
        term = Q30_ONE;
        for (n = 1; n <= 24; n++) begin
            term = ((term * z) >> 30) / 64'(n);
            sum  = sum + term;
        end
        if (k > 64'd20) begin
            k = 64'd20;
        end
        return sum << k;
    endfunction

    // sin of (pi/2)*u/SINE_TABLE_DEPTH, Q30, clipped at zero
    function automatic logic [63:0] sin_quadrant_q30(input logic [63:0] u);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        longint      sum;
        int          n;
        z    = (HALF_PI_Q30 * u) / 64'(SINE_TABLE_DEPTH);
        z2   = (z * z) >> 30;
        term = z;
        sum  = longint'(z);
        for (n = 1; n <= 12; n++) begin
            term = ((term * z2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        return 64'(sum);
    endfunction

    function automatic t_phase_rom build_phase_rom();
        t_phase_rom  rom;
        logic [63:0] lf;
        logic [63:0] f;
        logic [63:0] p;
        int          i;
        lf = log2_q30(64'(IMAGE_WIDTH / 10));
        for (i = 0; i < IMAGE_WIDTH; i++) begin
            f      = exp2_q30((lf * 64'(i + 1)) / 64'(IMAGE_WIDTH));
            p      = (64'(i) * f) / 64'(IMAGE_WIDTH);
            rom[i] = PHASE_W'((p + (64'd1 << 13)) >> 14);
        end
        return rom;
    endfunction

    function automatic t_amp_rom build_amp_rom();
        t_amp_rom    rom;
        logic [63:0] la;
        logic [63:0] a;
        logic [63:0] q;
        int          i;
        la = log2_q30(64'd255);
        for (i = 0; i < IMAGE_HEIGHT; i++) begin
            a = exp2_q30((la * 64'(i + 1)) / 64'(IMAGE_HEIGHT));
            q = (a + (64'd1 << 22)) >> 23;
            if (q > 64'hFFFF) begin
                q = 64'hFFFF;
            end
            rom[i] = AMP_W'(q);
        end
        return rom;
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] d;
        logic [63:0] u;
        logic [63:0] s;
        logic        neg;
        int          i;
        d = 64'(SINE_TABLE_DEPTH);
        for (i = 0; i < SINE_TABLE_DEPTH; i++) begin
            u   = 64'd4 * 64'(i);
            neg = 1'b0;
            if (u >= 64'd2 * d) begin
                neg = 1'b1;
                u   = u - 64'd2 * d;
            end
            if (u > d) begin
                u = 64'd2 * d - u;
            end
            s = (sin_quadrant_q30(u) + (64'd1 << 14)) >> 15;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            rom[i] = neg ? -SINE_W'(s) : SINE_W'(s);
        end
        return rom;
    endfunction

endpackage

[src/csp_coord_if.sv]
// ----------------------------------------------------------------------------
// csp_coord_if
// Valid/ready channel carrying one pixel position (column, row).
// ----------------------------------------------------------------------------
interface csp_coord_if;
    import csp_pkg::*;

    logic                valid;
    logic                ready;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row;

    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

[src/csp_pixel_if.sv]
// ----------------------------------------------------------------------------
// csp_pixel_if
// Valid/ready channel carrying one 8-bit gray pixel.
// ----------------------------------------------------------------------------
interface csp_pixel_if;
    import csp_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

[src/contrast_sweep_pattern_generator.sv]
// ----------------------------------------------------------------------------
// contrast_sweep_pattern_generator
// Contrast sweep chart: gray level per (column, row), six-stage pipeline.
// ----------------------------------------------------------------------------
// One pixel position goes in per clock and one gray value comes out per
// clock while the output is not held by back-pressure; the gray value of a
// position passes through the stages in order into the output register. The
// stages are: clamp of the position to the raster, registered column phase
// and row amplitude ROM reads, phase to sine index scaling, registered sine
// ROM read, amplitude times sine multiply, and bias/clamp into the output
// register. Every stage holds its own valid bit and loads whenever it is
// empty or is being drained, so back-pressure on the output only stalls as
// far as there are full stages, and bubbles are squeezed out. Positions
// beyond the raster are treated as the last column or row. The ROM contents
// are constants; there is no start-up pass.
module contrast_sweep_pattern_generator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    csp_coord_if.sink    i_coord,
    csp_pixel_if.source  o_pix
);
    import csp_pkg::*;

    localparam int NUM_STAGES = 6;

    localparam int COL_ADDR_W = $clog2(IMAGE_WIDTH);
    localparam int ROW_ADDR_W = $clog2(IMAGE_HEIGHT);
    localparam int COL_CMP_W  = (COLUMN_W > $clog2(IMAGE_WIDTH + 1)) ?
                                COLUMN_W : $clog2(IMAGE_WIDTH + 1);
    localparam int ROW_CMP_W  = (ROW_W > $clog2(IMAGE_HEIGHT + 1)) ?
                                ROW_W : $clog2(IMAGE_HEIGHT + 1);

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int PM_W  = PHASE_W + $clog2(SINE_TABLE_DEPTH + 1);

    localparam int PROD_W   = AMP_W + 1 + SINE_W;
    localparam int ACC_W    = PROD_W + 1;
    localparam int ACC_FRAC = 23;

    localparam logic signed [ACC_W-1:0] ACC_BIAS = ACC_W'(255) << 22;

    localparam t_phase_rom PHASE_ROM = build_phase_rom();
    localparam t_amp_rom   AMP_ROM   = build_amp_rom();
    localparam t_sine_rom  SINE_ROM  = build_sine_rom();

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] w_ld;

    logic [COL_ADDR_W-1:0]     r_s1_col;
    logic [ROW_ADDR_W-1:0]     r_s1_row;
    logic [PHASE_W-1:0]        r_s2_phase;
    logic [AMP_W-1:0]          r_s2_amp;
    logic [IDX_W-1:0]          r_s3_idx;
    logic [AMP_W-1:0]          r_s3_amp;
    logic signed [SINE_W-1:0]  r_s4_sin;
    logic [AMP_W-1:0]          r_s4_amp;
    logic signed [PROD_W-1:0]  r_s5_prod;
    logic [PIXEL_W-1:0]        r_s6_pixel;

    logic [COL_ADDR_W-1:0]     w_col;
    logic [ROW_ADDR_W-1:0]     w_row;
    logic [PM_W-1:0]           w_pm;
    logic signed [ACC_W-1:0]   w_acc;
    logic [PIXEL_W-1:0]        w_pixel;

    // a stage loads when empty or when its content moves on this cycle
    always_comb begin
        w_ld[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_pix.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
    end

    assign n_vld         = {r_vld[NUM_STAGES-2:0], i_coord.valid};
    assign i_coord.ready = w_ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // stage 1: clamp to the raster
    always_comb begin
        if (COL_CMP_W'(i_coord.column) >= COL_CMP_W'(IMAGE_WIDTH)) begin
            w_col = COL_ADDR_W'(IMAGE_WIDTH - 1);
        end else begin
            w_col = COL_ADDR_W'(i_coord.column);
        end
        if (ROW_CMP_W'(i_coord.row) >= ROW_CMP_W'(IMAGE_HEIGHT)) begin
            w_row = ROW_ADDR_W'(IMAGE_HEIGHT - 1);
        end else begin
            w_row = ROW_ADDR_W'(i_coord.row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_s1_col <= w_col;
            r_s1_row <= w_row;
        end
    end

    // stage 2: column phase and row amplitude lookups
    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r_s2_phase <= PHASE_ROM[r_s1_col];
            r_s2_amp   <= AMP_ROM[r_s1_row];
        end
    end

    // stage 3: phase fraction scaled to a sine index, always below the depth
    assign w_pm = PM_W'(r_s2_phase) * PM_W'(SINE_TABLE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (w_ld[2]) begin
            r_s3_idx <= w_pm[PHASE_W +: IDX_W];
            r_s3_amp <= r_s2_amp;
        end
    end

    // stage 4: sine lookup
    always_ff @(posedge i_clk) begin
        if (w_ld[3]) begin
            r_s4_sin <= SINE_ROM[r_s3_idx];
            r_s4_amp <= r_s3_amp;
        end
    end

    // stage 5: Q8.8 * Q1.15 -> Q.23
    always_ff @(posedge i_clk) begin
        if (w_ld[4]) begin
            r_s5_prod <= $signed({1'b0, r_s4_amp}) * r_s4_sin;
        end
    end

    // stage 6: add 127.5, truncate, clamp to 0..255
    assign w_acc = ACC_W'(r_s5_prod) + ACC_BIAS;

    always_comb begin
        if (w_acc[ACC_W-1]) begin
            w_pixel = '0;
        end else if (|w_acc[ACC_W-2:ACC_FRAC+PIXEL_W]) begin
            w_pixel = '1;
        end else begin
            w_pixel = w_acc[ACC_FRAC +: PIXEL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[5]) begin
            r_s6_pixel <= w_pixel;
        end
    end

    assign o_pix.valid = r_vld[NUM_STAGES-1];
    assign o_pix.pixel = r_s6_pixel;

    // an accepted transfer always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_coord.valid && i_coord.ready |=> r_vld[0])
        else $error("accepted position not captured in stage 1");

    // clamped position is inside the raster
    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (COL_CMP_W'(r_s1_col) < COL_CMP_W'(IMAGE_WIDTH)) &&
                     (ROW_CMP_W'(r_s1_row) < ROW_CMP_W'(IMAGE_HEIGHT)))
        else $error("clamped position outside raster");

    // sine index never runs past the table
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (32'(r_s3_idx) < 32'(SINE_TABLE_DEPTH)))
        else $error("sine index out of range");

    // a full stage that cannot move keeps its content
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] && !w_ld[4] |=> r_vld[3] && $stable(r_s4_sin) && $stable(r_s4_amp))
        else $error("stalled stage 4 lost its transfer");

endmodule

[bench/contrast_sweep_pattern_generator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contrast_sweep_pattern_generator_tb
// Self-checking bench for the contrast sweep chart generator. Positions are
// streamed in bursts against a receiver with its own stall pattern. Every
// accepted position gets its gray level worked out by an integer model of
// the chart, and the results are checked in order as they leave the block.
// ----------------------------------------------------------------------------
module contrast_sweep_pattern_generator_tb;
    import csp_pkg::*;

    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
    } t_position;

    // Integer model of the chart plus the in-order store of expected pixels.
    class chart_scoreboard;
        logic [PHASE_W-1:0] col_phase [IMAGE_WIDTH];
        logic [AMP_W-1:0]   row_gain  [IMAGE_HEIGHT];
        int                 sine_q15  [SINE_TABLE_DEPTH];
        logic [PIXEL_W-1:0] expected_pixels [$];
        int                 failures;

        function new();
            logic [63:0] lf;
            logic [63:0] la;
            logic [63:0] f;
            logic [63:0] p;
            logic [63:0] q;
            logic [63:0] u;
            logic [63:0] s;
            logic [63:0] d;
            logic        neg;
            int          i;
            failures = 0;
            lf = q30_log2(64'(IMAGE_WIDTH / 10));
            la = q30_log2(64'd255);
            for (i = 0; i < IMAGE_WIDTH; i++) begin
                f = q30_exp2((lf * 64'(i + 1)) / 64'(IMAGE_WIDTH));
                p = (64'(i) * f) / 64'(IMAGE_WIDTH);
                col_phase[i] = PHASE_W'((p + (64'd1 << 13)) >> 14);
            end
            for (i = 0; i < IMAGE_HEIGHT; i++) begin
                q = (q30_exp2((la * 64'(i + 1)) / 64'(IMAGE_HEIGHT)) + (64'd1 << 22)) >> 23;
                row_gain[i] = (q > 64'hFFFF) ? 16'hFFFF : AMP_W'(q);
            end
            d = 64'(SINE_TABLE_DEPTH);
            for (i = 0; i < SINE_TABLE_DEPTH; i++) begin
                u   = 64'd4 * 64'(i);
                neg = (u >= 64'd2 * d);
                if (neg) begin
                    u = u - 64'd2 * d;
                end
                if (u > d) begin
                    u = 64'd2 * d - u;
                end
                s = (q30_quarter_sine(u) + (64'd1 << 14)) >> 15;
                if (s > 64'd32767) begin
                    s = 64'd32767;
                end
                sine_q15[i] = neg ? -int'(s) : int'(s);
            end
        endfunction

        function logic [63:0] q30_log2(input logic [63:0] b);
            logic [63:0] v;
            logic [63:0] m;
            logic [63:0] res;
            int          msb;
            int          i;
            v   = (b == 64'd0) ? 64'd1 : b;
            msb = 0;
            for (i = 0; i < 64; i++) begin
                if (v[i]) begin
                    msb = i;
                end
            end
            m   = (v << 30) >> msb;
            res = 64'(msb) << 30;
            // squaring the mantissa yields one fraction bit per pass
            for (i = 1; i <= 30; i++) begin
                m = (m * m) >> 30;
                if (m >= (Q30_ONE << 1)) begin
                    m = m >> 1;
                    res[30-i] = 1'b1;
                end
            end
            return res;
        endfunction

        function logic [63:0] q30_exp2(input logic [63:0] y);
            logic [63:0] k;
            logic [63:0] z;
            logic [63:0] acc;
            logic [63:0] term;
            int          n;
            k    = y >> 30;
            z    = ((y & Q30_MASK) * LN2_Q30) >> 30;
            acc  = Q30_ONE;
            term = Q30_ONE;
            for (n = 1; n <= 24; n++) begin
                term = ((term * z) >> 30) / 64'(n);
                acc  = acc + term;
            end
            if (k > 64'd20) begin
                k = 64'd20;
            end
            return acc << k;
        endfunction

        // sin((pi/2) * u / depth), Q30, floored at zero
        function logic [63:0] q30_quarter_sine(input logic [63:0] u);
            logic [63:0] z;
            logic [63:0] z2;
            logic [63:0] term;
            longint      acc;
            int          n;
            z    = (HALF_PI_Q30 * u) / 64'(SINE_TABLE_DEPTH);
            z2   = (z * z) >> 30;
            term = z;
            acc  = longint'(z);
            for (n = 1; n <= 12; n++) begin
                term = ((term * z2) >> 30) / 64'((2 * n) * (2 * n + 1));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            return (acc < 0) ? 64'd0 : 64'(acc);
        endfunction

        function logic [PIXEL_W-1:0] gray_level(input logic [COLUMN_W-1:0] column,
                                                input logic [ROW_W-1:0]    row);
            int     x;
            int     y;
            int     idx;
            longint acc;
            x   = (column >= IMAGE_WIDTH) ? IMAGE_WIDTH - 1 : int'(column);
            y   = (row >= IMAGE_HEIGHT) ? IMAGE_HEIGHT - 1 : int'(row);
            idx = (int'(col_phase[x]) * SINE_TABLE_DEPTH) >> 16;
            if (idx >= SINE_TABLE_DEPTH) begin
                idx = SINE_TABLE_DEPTH - 1;
            end
            acc = (longint'(255) << 22) + longint'(row_gain[y]) * longint'(sine_q15[idx]);
            if (acc < 0) begin
                return '0;
            end
            acc = acc >>> 23;
            return (acc > 255) ? 8'd255 : PIXEL_W'(acc);
        endfunction

        function void note_position(input logic [COLUMN_W-1:0] column,
                                    input logic [ROW_W-1:0]    row);
            expected_pixels.push_back(gray_level(column, row));
        endfunction

        function void check_pixel(input logic [PIXEL_W-1:0] actual);
            logic [PIXEL_W-1:0] want;
            if (expected_pixels.size() == 0) begin
                failures++;
                $display("%0t: pixel %0d arrived with no position pending", $time, actual);
            end else begin
                want = expected_pixels.pop_front();
                if (want !== actual) begin
                    failures++;
                    $display("%0t: pixel mismatch, expected %0d actual %0d",
                             $time, want, actual);
                end
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    csp_coord_if     coord ();
    csp_pixel_if     pix ();
    chart_scoreboard board;
    t_position       position_queue [$];
    int              rx_stall_pct;
    logic [7:0]      rx_tick;

    contrast_sweep_pattern_generator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coord (coord),
        .o_pix   (pix)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: random stalls plus a periodic stall window, both off when rx_stall_pct is zero
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 8'd1;
        if (rx_stall_pct == 0) begin
            pix.ready <= 1'b1;
        end else if (rx_tick[4:0] > 5'd27) begin
            pix.ready <= 1'b0;
        end else begin
            pix.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (coord.valid && coord.ready) begin
                board.note_position(coord.column, coord.row);
            end
            if (pix.valid && pix.ready) begin
                board.check_pixel(pix.pixel);
            end
        end
    end

    task automatic queue_position(input int column, input int row);
        t_position p;
        p.column = COLUMN_W'(column);
        p.row    = ROW_W'(row);
        position_queue.push_back(p);
    endtask

    // mostly short scan-line runs, some scattered points, a few anywhere
    task automatic queue_random(input int count);
        int made;
        int kind;
        int len;
        int c0;
        int r;
        int k;
        made = 0;
        while (made < count) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                len = $urandom_range(1, 40);
                c0  = $urandom_range(0, IMAGE_WIDTH - 1);
                r   = $urandom_range(0, IMAGE_HEIGHT - 1);
                for (k = 0; k < len && c0 + k < 1024 && made < count; k++) begin
                    queue_position(c0 + k, r);
                    made++;
                end
            end else if (kind < 9) begin
                queue_position($urandom_range(0, IMAGE_WIDTH - 1),
                               $urandom_range(0, IMAGE_HEIGHT - 1));
                made++;
            end else begin
                queue_position($urandom_range(0, 1023), $urandom_range(0, 1023));
                made++;
            end
        end
    endtask

    // drain the position queue in bursts; gap_max of zero keeps valid high
    task automatic stream_positions(input int gap_max);
        t_position p;
        int        burst;
        int        gap;
        while (position_queue.size() > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && position_queue.size() > 0) begin
                p = position_queue.pop_front();
                coord.valid  <= 1'b1;
                coord.column <= p.column;
                coord.row    <= p.row;
                do @(posedge i_clk); while (!coord.ready);
                burst--;
            end
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                coord.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        coord.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        coord.valid  = 1'b0;
        coord.column = '0;
        coord.row    = '0;
        pix.ready    = 1'b0;
        rx_tick      = '0;
        rx_stall_pct = 0;
        board        = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners, raster edges, out-of-raster saturation, alternating bits
        queue_position(0, 0);
        queue_position(IMAGE_WIDTH - 1, IMAGE_HEIGHT - 1);
        queue_position(0, IMAGE_HEIGHT - 1);
        queue_position(IMAGE_WIDTH - 1, 0);
        queue_position(IMAGE_WIDTH, IMAGE_HEIGHT);
        queue_position(1023, 1023);
        queue_position(1023, 0);
        queue_position(0, 1023);
        queue_position(341, 682);
        queue_position(682, 341);
        queue_position(1, 1);
        queue_position(IMAGE_WIDTH - 2, IMAGE_HEIGHT - 2);
        queue_position(IMAGE_WIDTH / 2, IMAGE_HEIGHT / 2);
        queue_position(512, 512);
        queue_position(10, 300);
        queue_position(799, 300);
        rx_stall_pct = 20;
        stream_positions(3);
        wait_drained();

        // back-to-back stretch, no stalls
        rx_stall_pct = 0;
        queue_random(200);
        stream_positions(0);
        @(posedge i_clk);

        rx_stall_pct = 30;
        queue_random(220);
        stream_positions(8);
        wait_drained();

        rx_stall_pct = 65;
        queue_random(220);
        stream_positions(12);

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
src/csp_pkg.sv
src/csp_coord_if.sv
src/csp_pixel_if.sv
src/contrast_sweep_pattern_generator.sv
bench/contrast_sweep_pattern_generator_tb.sv
